// ===== hdl/smi_pkg.sv =====
// ----------------------------------------------------------------------------
// smi_pkg
// Types and constants shared by the small matrix inverse pipeline.
// ----------------------------------------------------------------------------
package smi_pkg;

  localparam int unsigned ENTRY_W    = 32;
  localparam int unsigned THR_W      = 31;
  localparam int unsigned N_ENTRIES  = 9;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned COF_W      = 65;
  localparam int unsigned PART_W     = 66;
  localparam int unsigned DET_W      = 98;
  localparam int unsigned DMAG_W     = 97;
  localparam int unsigned NMAG_W     = 64;
  localparam int unsigned REM_W      = 96;
  localparam int unsigned CMP_W      = 129;
  localparam int unsigned QUO_W      = 32;
  localparam int unsigned NUM_STAGES = 39;
  localparam int unsigned DIV_FIRST  = 5;
  localparam int unsigned DIV_STAGES = 33;

  localparam logic [THR_W-1:0] DET_THR_RESET = 31'd7;
  localparam logic [QUO_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef entry_t [N_ENTRIES-1:0] mat_t;
  typedef logic [COF_W-1:0] cof_t;
  typedef cof_t [N_ENTRIES-1:0] cof_mat_t;

  typedef struct packed {
    logic   size_is_three;
    entry_t m11;
    entry_t m12;
    entry_t m13;
    entry_t m21;
    entry_t m22;
    entry_t m23;
    entry_t m31;
    entry_t m32;
    entry_t m33;
  } in_t;

  typedef struct packed {
    logic   singular;
    entry_t r11;
    entry_t r12;
    entry_t r13;
    entry_t r21;
    entry_t r22;
    entry_t r23;
    entry_t r31;
    entry_t r32;
    entry_t r33;
  } out_t;

endpackage

// ===== hdl/smi_cofactor.sv =====
// ----------------------------------------------------------------------------
// smi_cofactor
// Two stages: the eighteen entry products, then the nine cofactor differences.
// ----------------------------------------------------------------------------
module smi_cofactor (
  input  logic                clk_i,
  input  logic [1:0]          en_i,
  input  smi_pkg::mat_t       a_i,
  input  logic                three_i,
  output smi_pkg::mat_t       a_o,
  output logic                three_o,
  output smi_pkg::cof_mat_t   cof_o
);

  localparam int PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int PC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int PD [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic signed [smi_pkg::PROD_W-1:0] pp_q [9];
  logic signed [smi_pkg::PROD_W-1:0] pn_q [9];
  smi_pkg::mat_t                     a0_q, a1_q;
  logic                              three0_q, three1_q;
  smi_pkg::cof_mat_t                 cof_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < 9; k++) begin
        pp_q[k] <= $signed(a_i[PA[k]]) * $signed(a_i[PB[k]]);
        pn_q[k] <= $signed(a_i[PC[k]]) * $signed(a_i[PD[k]]);
      end
      a0_q     <= a_i;
      three0_q <= three_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int k = 0; k < 9; k++) begin
        cof_q[k] <= smi_pkg::COF_W'(pp_q[k]) - smi_pkg::COF_W'(pn_q[k]);
      end
      a1_q     <= a0_q;
      three1_q <= three0_q;
    end
  end

  assign a_o     = a1_q;
  assign three_o = three1_q;
  assign cof_o   = cof_q;

endmodule

// ===== hdl/smi_det.sv =====
// ----------------------------------------------------------------------------
// smi_det
// Two stages: split partial products of the first row with its cofactors, then
// the determinant sum and the choice of adjugate and divisor for the size.
// ----------------------------------------------------------------------------
module smi_det (
  input  logic                              clk_i,
  input  logic [1:0]                        en_i,
  input  smi_pkg::mat_t                     a_i,
  input  logic                              three_i,
  input  smi_pkg::cof_mat_t                 cof_i,
  output smi_pkg::mat_t                     a_o,
  output logic                              three_o,
  output smi_pkg::cof_mat_t                 adj_o,
  output logic signed [smi_pkg::DET_W-1:0]  den_o
);

  localparam int CI [3] = '{0, 3, 6};

  logic signed [smi_pkg::PART_W-1:0] plo_q [3];
  logic signed [smi_pkg::PART_W-1:0] phi_q [3];
  smi_pkg::mat_t                     a2_q, a3_q;
  logic                              three2_q, three3_q;
  smi_pkg::cof_mat_t                 cof2_q, adj_q;
  logic signed [smi_pkg::DET_W-1:0]  den_q, det3;
  smi_pkg::cof_mat_t                 adj_d;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int j = 0; j < 3; j++) begin
        plo_q[j] <= $signed(a_i[j]) * $signed({1'b0, cof_i[CI[j]][31:0]});
        phi_q[j] <= $signed(a_i[j]) * $signed(cof_i[CI[j]][64:32]);
      end
      a2_q     <= a_i;
      three2_q <= three_i;
      cof2_q   <= cof_i;
    end
  end

  always_comb begin
    det3 = '0;
    for (int j = 0; j < 3; j++) begin
      det3 = det3 + (smi_pkg::DET_W'(phi_q[j]) <<< 32) + smi_pkg::DET_W'(plo_q[j]);
    end
    if (three2_q) begin
      adj_d = cof2_q;
    end else begin
      adj_d    = '0;
      adj_d[0] = smi_pkg::COF_W'($signed(a2_q[4]));
      adj_d[1] = -smi_pkg::COF_W'($signed(a2_q[1]));
      adj_d[3] = -smi_pkg::COF_W'($signed(a2_q[3]));
      adj_d[4] = smi_pkg::COF_W'($signed(a2_q[0]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      den_q    <= three2_q ? det3 : smi_pkg::DET_W'($signed(cof2_q[8]));
      adj_q    <= adj_d;
      a3_q     <= a2_q;
      three3_q <= three2_q;
    end
  end

  assign a_o     = a3_q;
  assign three_o = three3_q;
  assign adj_o   = adj_q;
  assign den_o   = den_q;

endmodule

// ===== hdl/smi_divider.sv =====
// ----------------------------------------------------------------------------
// smi_divider
// Pipelined restoring divider: one range check stage, then one quotient bit
// per stage, with saturation of the signed result at the end.
// ----------------------------------------------------------------------------
module smi_divider (
  input  logic                                clk_i,
  input  logic [smi_pkg::DIV_STAGES-1:0]      en_i,
  input  logic [smi_pkg::NMAG_W-1:0]          num_i,
  input  logic [smi_pkg::DMAG_W-1:0]          den_i,
  input  logic                                neg_i,
  output logic [smi_pkg::QUO_W-1:0]           res_o
);

  localparam int unsigned LAST = smi_pkg::DIV_STAGES - 1;

  logic [smi_pkg::REM_W-1:0]  rem_q [smi_pkg::DIV_STAGES];
  logic [smi_pkg::DMAG_W-1:0] den_q [smi_pkg::DIV_STAGES];
  logic [smi_pkg::QUO_W-1:0]  quo_q [smi_pkg::DIV_STAGES];
  logic                       ovf_q [smi_pkg::DIV_STAGES];
  logic                       neg_q [smi_pkg::DIV_STAGES];
  logic [smi_pkg::REM_W-1:0]  num_sh;
  logic [smi_pkg::QUO_W-1:0]  quo;

  assign num_sh = {num_i, 32'b0};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= num_sh;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= {33'b0, num_sh} >= {den_i, 32'b0};
    end
  end

  for (genvar j = 1; j <= LAST; j++) begin : g_step
    localparam int unsigned K = LAST - j;
    logic [smi_pkg::CMP_W-1:0] shd, ext;
    logic                      ge;
    assign shd = {32'b0, den_q[j-1]} << K;
    assign ext = {33'b0, rem_q[j-1]};
    assign ge  = ext >= shd;
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= ge ? smi_pkg::REM_W'(ext - shd) : rem_q[j-1];
        quo_q[j] <= quo_q[j-1] | (smi_pkg::QUO_W'(ge) << K);
        den_q[j] <= den_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign quo = quo_q[LAST];

  always_comb begin
    if (neg_q[LAST]) begin
      res_o = (ovf_q[LAST] || quo > smi_pkg::SAT_MIN) ? smi_pkg::SAT_MIN : -quo;
    end else begin
      res_o = (ovf_q[LAST] || quo[31]) ? smi_pkg::SAT_MAX : quo;
    end
  end

endmodule

// ===== hdl/small_matrix_inverse.sv =====
// ----------------------------------------------------------------------------
// small_matrix_inverse
// Inverse of a 2x2 or 3x3 matrix of signed Q16.16 entries by the adjugate
// method, with a singularity threshold and saturated results.
// ----------------------------------------------------------------------------
// The block is a 39-stage pipeline that takes one matrix in every cycle while
// the input is not stalled. The divider makes up most of the stages; it
// resolves one quotient bit per stage for each of the nine entries, and the
// products and the determinant take five stages before it.
// Every stage holds its item until the next one is free, so a stall at the
// output fills empty stages first and reaches the input only when the pipeline
// is full.
module small_matrix_inverse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  smi_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output smi_pkg::out_t               out_data_o,
  input  logic                        cfg_we_i,
  input  logic [smi_pkg::THR_W-1:0]   cfg_data_i
);

  localparam int unsigned NS   = smi_pkg::NUM_STAGES;
  localparam int unsigned DF   = smi_pkg::DIV_FIRST;
  localparam int unsigned DL   = DF + smi_pkg::DIV_STAGES - 1;

  logic [NS-1:0]                   v_q;
  logic [NS-1:0]                   en;
  logic [smi_pkg::THR_W-1:0]       thr_q;
  smi_pkg::mat_t                   a_in, a1, a3;
  logic                            three1, three3;
  smi_pkg::cof_mat_t               cof1, adj3;
  logic signed [smi_pkg::DET_W-1:0] den3;

  logic [smi_pkg::DMAG_W-1:0]      dmag4_q;
  logic [smi_pkg::NMAG_W-1:0]      nmag4_q [9];
  logic [8:0]                      ng4_q;
  smi_pkg::mat_t                   a4_q;
  logic                            three4_q;
  logic [smi_pkg::DMAG_W-1:0]      lim;

  smi_pkg::mat_t                   ca_q [DF:DL];
  logic                            cs_q [DF:DL];
  smi_pkg::mat_t                   res;
  smi_pkg::mat_t                   r_out;
  smi_pkg::out_t                   out_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= smi_pkg::DET_THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Entries outside a 2x2 matrix enter as zero.
  always_comb begin
    a_in[0] = in_data_i.m11;
    a_in[1] = in_data_i.m12;
    a_in[3] = in_data_i.m21;
    a_in[4] = in_data_i.m22;
    a_in[2] = in_data_i.size_is_three ? in_data_i.m13 : '0;
    a_in[5] = in_data_i.size_is_three ? in_data_i.m23 : '0;
    a_in[6] = in_data_i.size_is_three ? in_data_i.m31 : '0;
    a_in[7] = in_data_i.size_is_three ? in_data_i.m32 : '0;
    a_in[8] = in_data_i.size_is_three ? in_data_i.m33 : '0;
  end

  smi_cofactor u_cof (
    .clk_i   (clk_i),
    .en_i    (en[1:0]),
    .a_i     (a_in),
    .three_i (in_data_i.size_is_three),
    .a_o     (a1),
    .three_o (three1),
    .cof_o   (cof1)
  );

  smi_det u_det (
    .clk_i   (clk_i),
    .en_i    (en[3:2]),
    .a_i     (a1),
    .three_i (three1),
    .cof_i   (cof1),
    .a_o     (a3),
    .three_o (three3),
    .adj_o   (adj3),
    .den_o   (den3)
  );

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      dmag4_q <= den3[smi_pkg::DET_W-1] ? smi_pkg::DMAG_W'(-den3) : smi_pkg::DMAG_W'(den3);
      for (int k = 0; k < 9; k++) begin
        nmag4_q[k] <= adj3[k][smi_pkg::COF_W-1] ? smi_pkg::NMAG_W'(-adj3[k])
                                                : smi_pkg::NMAG_W'(adj3[k]);
        ng4_q[k]   <= adj3[k][smi_pkg::COF_W-1] ^ den3[smi_pkg::DET_W-1];
      end
      a4_q     <= a3;
      three4_q <= three3;
    end
  end

  assign lim = three4_q ? smi_pkg::DMAG_W'({thr_q, 32'b0})
                        : smi_pkg::DMAG_W'({thr_q, 16'b0});

  always_ff @(posedge clk_i) begin
    if (en[DF]) begin
      cs_q[DF] <= (dmag4_q == '0) || (dmag4_q < lim);
      ca_q[DF] <= a4_q;
    end
    for (int k = DF + 1; k <= DL; k++) begin
      if (en[k]) begin
        cs_q[k] <= cs_q[k-1];
        ca_q[k] <= ca_q[k-1];
      end
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_div
    smi_divider u_div (
      .clk_i (clk_i),
      .en_i  (en[DL:DF]),
      .num_i (nmag4_q[k]),
      .den_i (dmag4_q),
      .neg_i (ng4_q[k]),
      .res_o (res[k])
    );
  end

  assign r_out = cs_q[DL] ? ca_q[DL] : res;

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q.singular <= cs_q[DL];
      out_q.r11      <= r_out[0];
      out_q.r12      <= r_out[1];
      out_q.r13      <= r_out[2];
      out_q.r21      <= r_out[3];
      out_q.r22      <= r_out[4];
      out_q.r23      <= r_out[5];
      out_q.r31      <= r_out[6];
      out_q.r32      <= r_out[7];
      out_q.r33      <= r_out[8];
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = out_q;

endmodule

// ===== hdl/smi_checker.sv =====
// ----------------------------------------------------------------------------
// smi_checker
// Port-level checks of the small matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
module smi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input smi_pkg::out_t out_data_o
);

  // The input is held back only when a finished result is waiting.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output could transfer");

  a_reset_empty : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result offered straight after reset");

  a_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result withdrawn");

  a_data_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind small_matrix_inverse smi_checker u_smi_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the small matrix inverse. Directed matrices, then
// random 2x2 and 3x3 matrices under several threshold settings, are compared
// field by field with an independent wide-integer inverse predictor, with
// random input bursts and output stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned N_RANDOM = 1900;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  smi_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  smi_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [smi_pkg::THR_W-1:0] cfg_data_i = '0;

  typedef struct {
    smi_pkg::in_t mat;
    logic chk;
    smi_pkg::out_t res;
  } row_t;

  smi_pkg::out_t inverse_q[$];
  logic [smi_pkg::THR_W-1:0] threshold;
  int mismatches = 0;
  logic stall_hold = 1'b0;

  small_matrix_inverse uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [31:0] div_sat(input logic signed [255:0] num,
                                                  input logic signed [255:0] den);
    logic signed [255:0] q;
    q = num / den;
    if (q > 256'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (q < -256'sh8000_0000) return 32'sh8000_0000;
    return q[31:0];
  endfunction

  function automatic smi_pkg::out_t invert(input smi_pkg::in_t x,
                                           input logic [smi_pkg::THR_W-1:0] thr);
    logic signed [255:0] a[9];
    logic signed [255:0] adj[9];
    logic signed [255:0] det, mag, lim;
    logic [31:0] e[9];
    logic [31:0] r[9];
    smi_pkg::out_t o;
    e = '{x.m11, x.m12, x.m13, x.m21, x.m22, x.m23, x.m31, x.m32, x.m33};
    for (int k = 0; k < 9; k++) begin
      a[k] = (x.size_is_three || k inside {0, 1, 3, 4}) ? 256'(signed'(e[k])) : 0;
      adj[k] = 0;
      r[k] = '0;
    end
    if (x.size_is_three) begin
      adj[0] = a[4] * a[8] - a[5] * a[7];
      adj[1] = a[2] * a[7] - a[1] * a[8];
      adj[2] = a[1] * a[5] - a[2] * a[4];
      adj[3] = a[5] * a[6] - a[3] * a[8];
      adj[4] = a[0] * a[8] - a[2] * a[6];
      adj[5] = a[2] * a[3] - a[0] * a[5];
      adj[6] = a[3] * a[7] - a[4] * a[6];
      adj[7] = a[1] * a[6] - a[0] * a[7];
      adj[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
      lim = 256'(thr) <<< 32;
    end else begin
      adj[0] = a[4];
      adj[1] = -a[1];
      adj[3] = -a[3];
      adj[4] = a[0];
      det = a[0] * a[4] - a[3] * a[1];
      lim = 256'(thr) <<< 16;
    end
    mag = det < 0 ? -det : det;
    o.singular = (mag == 0) || (mag < lim);
    for (int k = 0; k < 9; k++) begin
      if (!x.size_is_three && !(k inside {0, 1, 3, 4})) continue;
      r[k] = o.singular ? a[k][31:0] : div_sat(adj[k] <<< 32, det);
    end
    {o.r11, o.r12, o.r13, o.r21, o.r22, o.r23, o.r31, o.r32, o.r33} =
      {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]};
    return o;
  endfunction

  always @(posedge clk_i) begin
    smi_pkg::out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        report("unexpected transfer", 32'd1, 32'd0);
      end else begin
        want = inverse_q.pop_front();
        if (out_data_o.singular !== want.singular)
          report("singular", 32'(out_data_o.singular), 32'(want.singular));
        if (out_data_o.r11 !== want.r11) report("r11", out_data_o.r11, want.r11);
        if (out_data_o.r12 !== want.r12) report("r12", out_data_o.r12, want.r12);
        if (out_data_o.r13 !== want.r13) report("r13", out_data_o.r13, want.r13);
        if (out_data_o.r21 !== want.r21) report("r21", out_data_o.r21, want.r21);
        if (out_data_o.r22 !== want.r22) report("r22", out_data_o.r22, want.r22);
        if (out_data_o.r23 !== want.r23) report("r23", out_data_o.r23, want.r23);
        if (out_data_o.r31 !== want.r31) report("r31", out_data_o.r31, want.r31);
        if (out_data_o.r32 !== want.r32) report("r32", out_data_o.r32, want.r32);
        if (out_data_o.r33 !== want.r33) report("r33", out_data_o.r33, want.r33);
      end
    end
  end

  // The receiver alternates between free-running stretches and stall patterns.
  always @(posedge clk_i) begin
    if (!stall_hold) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 99) < 45);
  end

  initial begin
    forever begin
      repeat ($urandom_range(20, 300)) @(posedge clk_i);
      stall_hold = ~stall_hold;
    end
  end

  task automatic send(input smi_pkg::in_t m, input logic chk, input smi_pkg::out_t res);
    smi_pkg::out_t want;
    want = invert(m, threshold);
    if (chk && want !== res) begin
      report("directed row", 32'd1, 32'd0);
    end
    in_valid_i <= 1'b1;
    in_data_i <= m;
    inverse_q = {inverse_q, want};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [smi_pkg::THR_W-1:0] v);
    in_valid_i <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = v;
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'(signed'($urandom_range(0, 512)) - 256);
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return 32'($urandom_range(0, 4)) << 16;
    endcase
  endfunction

  function automatic smi_pkg::in_t rand_matrix();
    smi_pkg::in_t m;
    m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, 1'b0};
    m.size_is_three = 1'($urandom_range(0, 1));
    m.m11 = rand_entry(); m.m12 = rand_entry(); m.m21 = rand_entry();
    m.m22 = rand_entry();
    if (m.size_is_three || $urandom_range(0, 1)) begin
      m.m13 = rand_entry(); m.m23 = rand_entry(); m.m31 = rand_entry();
      m.m32 = rand_entry(); m.m33 = rand_entry();
    end
    if ($urandom_range(0, 15) == 0) m.m21 = m.m11;
    if ($urandom_range(0, 15) == 0) begin
      m.m21 = m.m11; m.m22 = m.m12; m.m23 = m.m13;
    end
    return m;
  endfunction

  localparam smi_pkg::entry_t ONE = 32'h0001_0000;
  localparam smi_pkg::entry_t MX = 32'h7FFF_FFFF;
  localparam smi_pkg::entry_t MN = 32'h8000_0000;

  row_t dir_rows [14] = '{
    '{'{1'b0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0}, 1'b1,
      '{1'b0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0}},
    '{'{1'b1, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1,
      '{1'b0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}},
    '{'{1'b0, 0, 0, 5, 0, 0, 6, 7, 8, 9}, 1'b1,
      '{1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{'{1'b1, ONE, ONE, ONE, ONE, ONE, ONE, 3, 4, 5}, 1'b1,
      '{1'b1, ONE, ONE, ONE, ONE, ONE, ONE, 3, 4, 5}},
    '{'{1'b0, 1, 0, 0, 0, 1, 0, 0, 0, 0}, 1'b1,
      '{1'b1, 1, 0, 0, 0, 1, 0, 0, 0, 0}},
    '{'{1'b0, 1, 0, 0, 0, 1, 0, 0, 0, 0}, 1'b0, '{default: '0}},
    '{'{1'b0, MX, 0, 0, 0, MX, 0, 0, 0, 0}, 1'b0, '{default: '0}},
    '{'{1'b0, MN, MX, MN, MX, MN, MX, MN, MX, MN}, 1'b0, '{default: '0}},
    '{'{1'b1, MN, 0, 0, 0, MN, 0, 0, 0, MN}, 1'b0, '{default: '0}},
    '{'{1'b1, MX, MN, MX, MN, MX, MN, MX, MN, MN}, 1'b0, '{default: '0}},
    '{'{1'b1, 0, ONE, 0, 0, 0, ONE, ONE, 0, 0}, 1'b0, '{default: '0}},
    '{'{1'b0, 256, 0, 0, 0, 256, 0, 0, 0, 0}, 1'b0, '{default: '0}},
    '{'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, MX, 0, 32'hFFFF_FFFF, MN, 0, 0, 0},
      1'b0, '{default: '0}},
    '{'{1'b1, 32'h0002_0000, 32'h0001_0000, 0, 32'hFFFF_0000, 32'h0003_0000, 0,
        0, 0, 32'h0000_8000}, 1'b0, '{default: '0}}
  };

  initial begin
    threshold = smi_pkg::DET_THR_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[k]) begin
      send(dir_rows[k].mat, dir_rows[k].chk, dir_rows[k].res);
      if ($urandom_range(0, 2) == 0) pause();
    end
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_threshold('0);
        1: set_threshold(31'h7FFF_FFFF);
        2: set_threshold(31'd1 << 16);
        3: set_threshold(smi_pkg::THR_W'($urandom));
        default: set_threshold(smi_pkg::DET_THR_RESET);
      endcase
      for (int n = 0; n < N_RANDOM / 5; ) begin
        repeat ($urandom_range(1, 40)) begin
          send(rand_matrix(), 1'b0, '0);
          n++;
        end
        if ($urandom_range(0, 3) != 0) pause();
      end
    end
    in_valid_i <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/smi_pkg.sv
hdl/smi_cofactor.sv
hdl/smi_det.sv
hdl/smi_divider.sv
hdl/small_matrix_inverse.sv
hdl/smi_checker.sv
sim/tb.sv
